// ===== rtl/lpb_pkg.sv =====
// ----------------------------------------------------------------------------
// lpb_pkg
// Types and constants shared by the largest-prime search controller,
// datapath and interfaces.
// ----------------------------------------------------------------------------
package lpb_pkg;

	// Width of the reported prime; wider candidates report their low bits.
	localparam int PRIME_WIDTH = 16;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_bound;  // capture the incoming bound
		logic first_cand;  // candidate := bound - 1, divisor := 2
		logic next_cand;   // candidate := candidate - 1, divisor := 2
		logic next_div;    // divisor := divisor + 1
		logic div_start;   // clear the remainder, start at the top bit
		logic div_step;    // one restoring division step
		logic load_out;    // move the answer into the output register
	} lpb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bound_small; // bound of two or less
		logic sq_gt;       // divisor squared exceeds the candidate
		logic div_last;    // current division step is the last one
		logic rem_zero;    // remainder of the finished division is zero
	} lpb_status_t;

endpackage

// ===== rtl/lpb_req_if.sv =====
// ----------------------------------------------------------------------------
// lpb_req_if
// Request channel: one beat carries an exclusive upper bound.
// ----------------------------------------------------------------------------
interface lpb_req_if #(
	parameter int BOUND_WIDTH = 16
) ();
	logic                   valid;
	logic                   ready;
	logic [BOUND_WIDTH-1:0] upper_bound;

	modport source (output valid, output upper_bound, input ready);
	modport sink   (input valid, input upper_bound, output ready);
endinterface

// ===== rtl/lpb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lpb_rsp_if
// Response channel: one beat carries the prime found and the none-found flag.
// ----------------------------------------------------------------------------
interface lpb_rsp_if ();
	logic                            valid;
	logic                            ready;
	logic [lpb_pkg::PRIME_WIDTH-1:0] largest_prime;
	logic                            none_found;

	modport source (output valid, output largest_prime, output none_found, input ready);
	modport sink   (input valid, input largest_prime, input none_found, output ready);
endinterface

// ===== rtl/largest_prime_below_bound_core.sv =====
// ----------------------------------------------------------------------------
// largest_prime_below_bound_core
// Returns the largest prime strictly below an unsigned bound.
// ----------------------------------------------------------------------------
// Usage: a beat on req carries upper_bound. One beat comes back on rsp with
// largest_prime and none_found; for a bound of two or less none_found is set
// and largest_prime is zero. Results leave in the order the bounds arrived.
// The search walks down from bound minus one and tests each candidate by
// trial division with divisors 2, 3, 4 ... until one divides it or the divisor
// squared exceeds it. Each division is bit-serial, one quotient bit a cycle;
// each divisor passes through the test, the division steps and the check,
// and a bound of two or less goes straight to the finish without a search.
// One query is worked on at a time; req.ready is high only while the
// sequencer is idle. The answer sits in an output register, so the next bound
// is taken while it waits; a stalled rsp holds its beat unchanged and holds
// back the following answer. Reset clears the sequencer and rsp.valid.
// ----------------------------------------------------------------------------
module largest_prime_below_bound_core #(
	parameter int BOUND_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	lpb_req_if.sink     req,
	lpb_rsp_if.source   rsp
);
	lpb_pkg::lpb_cmd_t    cmd;
	lpb_pkg::lpb_status_t status;

	lpb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.status    (status)
	);

	lpb_datapath #(
		.BOUND_WIDTH (BOUND_WIDTH)
	) u_datapath (
		.clk           (clk),
		.cmd           (cmd),
		.status        (status),
		.upper_bound   (req.upper_bound),
		.largest_prime (rsp.largest_prime),
		.none_found    (rsp.none_found)
	);
endmodule

// ===== rtl/lpb_datapath.sv =====
// ----------------------------------------------------------------------------
// lpb_datapath
// Candidate, divisor and square registers, a bit-serial restoring divider
// for the remainder, and the output register.
// ----------------------------------------------------------------------------
module lpb_datapath #(
	parameter int BOUND_WIDTH = 16
) (
	input  logic                            clk,
	input  lpb_pkg::lpb_cmd_t               cmd,
	output lpb_pkg::lpb_status_t            status,
	input  logic [BOUND_WIDTH-1:0]          upper_bound,
	output logic [lpb_pkg::PRIME_WIDTH-1:0] largest_prime,
	output logic                            none_found
);
	localparam int W   = BOUND_WIDTH;
	localparam int SQW = BOUND_WIDTH + 2;
	localparam int CW  = $clog2(BOUND_WIDTH);

	logic [W-1:0]   bound_q;
	logic [W-1:0]   cand_q;
	logic [W-1:0]   div_q;
	logic [SQW-1:0] sq_q;
	logic [W-1:0]   rem_q;
	logic [CW-1:0]  bit_q;
	logic [lpb_pkg::PRIME_WIDTH-1:0] prime_q;
	logic           none_q;

	logic [W:0]     trial;
	logic [W:0]     div_ext;
	logic [W:0]     diff;
	logic [W+lpb_pkg::PRIME_WIDTH-1:0] cand_wide;

	assign trial   = {rem_q, cand_q[bit_q]};
	assign div_ext = {1'b0, div_q};
	assign diff    = trial - div_ext;

	// Zero-extend before taking the low bits so that narrow bounds work too.
	assign cand_wide = {{lpb_pkg::PRIME_WIDTH{1'b0}}, cand_q};

	always_ff @(posedge clk) begin
		if (cmd.load_bound) begin
			bound_q <= upper_bound;
		end
		if (cmd.first_cand || cmd.next_cand) begin
			cand_q <= cmd.first_cand ? (bound_q - W'(1)) : (cand_q - W'(1));
			div_q  <= W'(2);
			sq_q   <= SQW'(4);
		end else if (cmd.next_div) begin
			// (d + 1)^2 = d^2 + 2d + 1
			div_q <= div_q + W'(1);
			sq_q  <= sq_q + {1'b0, div_q, 1'b1};
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			bit_q <= CW'(W - 1);
		end else if (cmd.div_step) begin
			rem_q <= (trial >= div_ext) ? diff[W-1:0] : trial[W-1:0];
			bit_q <= bit_q - CW'(1);
		end
		if (cmd.load_out) begin
			prime_q <= status.bound_small ? '0 : cand_wide[lpb_pkg::PRIME_WIDTH-1:0];
			none_q  <= status.bound_small;
		end
	end

	assign status.bound_small = (bound_q <= W'(2));
	assign status.sq_gt       = (sq_q > {2'b00, cand_q});
	assign status.div_last    = (bit_q == '0);
	assign status.rem_zero    = (rem_q == '0);

	assign largest_prime = prime_q;
	assign none_found    = none_q;
endmodule

// ===== rtl/lpb_ctrl.sv =====
// ----------------------------------------------------------------------------
// lpb_ctrl
// Sequencer for the downward candidate search and the trial division loop,
// and owner of the request and response handshakes.
// ----------------------------------------------------------------------------
module lpb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output lpb_pkg::lpb_cmd_t    cmd,
	input  lpb_pkg::lpb_status_t status
);
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_INIT   = 6'b000010,
		ST_TEST   = 6'b000100,
		ST_DIV    = 6'b001000,
		ST_CHECK  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_bound = 1'b1;
					state_d        = ST_INIT;
				end
			end
			ST_INIT: begin
				if (status.bound_small) begin
					state_d = ST_FINISH;
				end else begin
					cmd.first_cand = 1'b1;
					state_d        = ST_TEST;
				end
			end
			ST_TEST: begin
				// Once the divisor squared passes the candidate, it is prime.
				if (status.sq_gt) begin
					state_d = ST_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.rem_zero) begin
					cmd.next_cand = 1'b1;
				end else begin
					cmd.next_div = 1'b1;
				end
				state_d = ST_TEST;
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ===== rtl/lpb_checker.sv =====
// ----------------------------------------------------------------------------
// lpb_checker
// Port-level checks on the largest-prime core, bound to the top level.
// ----------------------------------------------------------------------------
module lpb_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [lpb_pkg::PRIME_WIDTH-1:0] largest_prime,
	input logic                            none_found
);
	// A stalled response beat stays and keeps its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(largest_prime) && $stable(none_found))
	else $error("response beat changed while stalled");

	// The none-found flag always comes with a zero prime.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && none_found |-> largest_prime == '0)
	else $error("none_found set with a nonzero prime");

	// Taking a bound starts a search, so the core is busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
	else $error("request accepted twice in a row");

	// A new answer only appears after a search, never out of the idle state.
	a_rsp_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
	else $error("response raised without a search in progress");
endmodule

bind largest_prime_below_bound_core lpb_checker u_lpb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.largest_prime (rsp.largest_prime),
	.none_found    (rsp.none_found)
);

// ===== verif/largest_prime_below_bound_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_prime_below_bound_core_tb
// Self-checking bench for the largest-prime search core. A table of edge
// bounds runs first, then a few hundred random bounds, mostly small so that the
// trial division stays short. Each response is checked against its fixed answer
// or a trial division model, under three patterns of source gaps and sink stalls.
// ----------------------------------------------------------------------------
module largest_prime_below_bound_core_tb;

	localparam int BOUND_W        = 16;
	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 6;
	localparam int RANDOM_ITEMS   = 480;
	localparam int DRAIN_CYCLES   = 64;
	localparam int WATCHDOG_LIMIT = 500000;
	localparam int MAX_REPORTS    = 10;
	localparam int DIR_N          = 22;

	typedef struct {
		logic [lpb_pkg::PRIME_WIDTH-1:0] largest_prime;
		logic                            none_found;
	} prime_result_t;

	typedef struct {
		logic [BOUND_W-1:0]              bound;
		bit                              fixed;
		logic [lpb_pkg::PRIME_WIDTH-1:0] largest_prime;
		logic                            none_found;
	} bound_row_t;

	// Rows marked fixed carry their answer; the rest go through the model.
	bound_row_t bound_rows [DIR_N] = '{
		'{16'd0,     1'b1, 16'd0,     1'b1},
		'{16'd1,     1'b1, 16'd0,     1'b1},
		'{16'd2,     1'b1, 16'd0,     1'b1},
		'{16'd3,     1'b1, 16'd2,     1'b0},
		'{16'd4,     1'b1, 16'd3,     1'b0},
		'{16'd65535, 1'b1, 16'd65521, 1'b0},
		'{16'd5,     1'b0, 16'd0,     1'b0},
		'{16'd6,     1'b0, 16'd0,     1'b0},
		'{16'd8,     1'b0, 16'd0,     1'b0},
		'{16'd9,     1'b0, 16'd0,     1'b0},
		'{16'd10,    1'b0, 16'd0,     1'b0},
		'{16'd25,    1'b0, 16'd0,     1'b0},
		'{16'd121,   1'b0, 16'd0,     1'b0},
		'{16'd128,   1'b0, 16'd0,     1'b0},
		'{16'd1024,  1'b0, 16'd0,     1'b0},
		'{16'd32768, 1'b0, 16'd0,     1'b0},
		'{16'd31469, 1'b0, 16'd0,     1'b0},
		'{16'd65521, 1'b0, 16'd0,     1'b0},
		'{16'd65522, 1'b0, 16'd0,     1'b0},
		'{16'd65534, 1'b0, 16'd0,     1'b0},
		'{16'hAAAA,  1'b0, 16'd0,     1'b0},
		'{16'h5555,  1'b0, 16'd0,     1'b0}
	};

	logic clk;
	logic arst_n;

	lpb_req_if #(.BOUND_WIDTH(BOUND_W)) req_ch ();
	lpb_rsp_if                          rsp_ch ();

	largest_prime_below_bound_core #(
		.BOUND_WIDTH(BOUND_W)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	prime_result_t pending_primes [$];
	bit            beat_fixed;
	prime_result_t beat_answer;
	int            send_idle_pct;
	int            stall_pct;
	int            bounds_sent;
	int            answers_checked;
	int            empty_answers;
	int            mismatches;
	int            quiet_cycles;

	// Trial division, downward from bound - 1, stopping at the first divisor.
	function automatic prime_result_t prime_below(logic [BOUND_W-1:0] bound);
		prime_result_t r;
		int            cand;
		int            d;
		bit            is_prime;
		r.largest_prime = '0;
		r.none_found    = 1'b1;
		if (bound > 2) begin
			for (cand = int'(bound) - 1; cand >= 2; cand--) begin
				is_prime = 1'b1;
				for (d = 2; d * d <= cand; d++) begin
					if (cand % d == 0) begin
						is_prime = 1'b0;
						break;
					end
				end
				if (is_prime) begin
					r.largest_prime = cand[lpb_pkg::PRIME_WIDTH-1:0];
					r.none_found    = 1'b0;
					break;
				end
			end
		end
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Sink side: stall at random, one decision per falling edge.
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Predict at request acceptance, compare at response acceptance.
	always @(posedge clk) begin
		prime_result_t want;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				if (beat_fixed)
					pending_primes.push_back(beat_answer);
				else
					pending_primes.push_back(prime_below(req_ch.upper_bound));
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				answers_checked++;
				if (rsp_ch.none_found)
					empty_answers++;
				if (pending_primes.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("ERROR: unexpected response prime=%0d none_found=%0b",
							rsp_ch.largest_prime, rsp_ch.none_found);
				end else begin
					want = pending_primes.pop_front();
					if (rsp_ch.largest_prime !== want.largest_prime ||
						rsp_ch.none_found !== want.none_found) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display({"ERROR: response %0d: prime %0d (expected %0d), ",
								"none_found %0b (expected %0b)"},
								answers_checked, rsp_ch.largest_prime, want.largest_prime,
								rsp_ch.none_found, want.none_found);
					end
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a beat.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("ERROR: no beat moved for %0d cycles", WATCHDOG_LIMIT);
			$display("largest_prime_below_bound_core test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One bound per call; the beat stays up until the core takes it.
	task automatic send_bound(input logic [BOUND_W-1:0] bound, input bit fixed,
		input prime_result_t answer);
		int phase;
		phase = bounds_sent * 3 / (DIR_N + RANDOM_ITEMS);
		case (phase)
			0: begin
				send_idle_pct = 15;
				stall_pct     = 65;
			end
			1: begin
				send_idle_pct = 65;
				stall_pct     = 15;
			end
			default: begin
				send_idle_pct = 0;
				stall_pct     = 0;
			end
		endcase
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		beat_fixed         = fixed;
		beat_answer        = answer;
		req_ch.valid       <= 1'b1;
		req_ch.upper_bound <= bound;
		do
			@(posedge clk);
		while (!(req_ch.valid && req_ch.ready));
		bounds_sent++;
		@(negedge clk);
	endtask

	initial begin
		prime_result_t      answer;
		logic [BOUND_W-1:0] bound;
		int                 pick;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.upper_bound = '0;
		rsp_ch.ready       = 1'b0;
		beat_fixed         = 1'b0;
		beat_answer        = '{'0, 1'b0};
		send_idle_pct      = 0;
		stall_pct          = 0;
		bounds_sent        = 0;
		answers_checked    = 0;
		empty_answers      = 0;
		mismatches         = 0;
		quiet_cycles       = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (bound_rows[i]) begin
			answer.largest_prime = bound_rows[i].largest_prime;
			answer.none_found    = bound_rows[i].none_found;
			send_bound(bound_rows[i].bound, bound_rows[i].fixed, answer);
		end

		// Small bounds keep the search short; a quarter span the full width.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(99);
			if (pick < 15)
				bound = BOUND_W'($urandom_range(4));
			else if (pick < 75)
				bound = BOUND_W'($urandom_range(1023));
			else
				bound = BOUND_W'($urandom);
			send_bound(bound, 1'b0, answer);
		end
		req_ch.valid <= 1'b0;

		while (pending_primes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bounds and checked %0d answers, %0d of them with no prime.",
			bounds_sent, answers_checked, empty_answers);
		$display("Source gaps and sink stalls were swapped between phases; %0d mismatches.",
			mismatches);
		if (mismatches == 0)
			$display("largest_prime_below_bound_core test passed");
		else
			$display("largest_prime_below_bound_core test failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lpb_pkg.sv
rtl/lpb_req_if.sv
rtl/lpb_rsp_if.sv
rtl/lpb_datapath.sv
rtl/lpb_ctrl.sv
rtl/largest_prime_below_bound_core.sv
rtl/lpb_checker.sv
verif/largest_prime_below_bound_core_tb.sv
